@@ src/lpc_pkg.sv @@
// lpc_pkg: shared constants and controller/datapath command and status types
// for the LZW phrase counter. No dependencies.
`default_nettype none

package lpc_pkg;

	localparam int LPC_ALPHABET = 26;
	localparam int LPC_NODES    = 4096;

	localparam int CHAR_W  = 8;
	localparam int COUNT_W = 20;

	// Case folding: bytes below FOLD_LIMIT are moved up by CASE_OFFSET,
	// then LOWER_A maps 'a' to letter code zero.
	localparam logic [CHAR_W-1:0] FOLD_LIMIT  = 8'd95;
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;
	localparam logic [CHAR_W-1:0] LOWER_A     = 8'd97;
	localparam logic [CHAR_W-1:0] LETTERS     = 8'd26;

	typedef struct packed {
		logic clear;      // start a new run before this character
		logic load_in;    // capture the input transaction
		logic calc_addr;  // form child table address
		logic rd_child;   // read child table
		logic rd_parent;  // read parent key of the child
		logic decide;     // walk, insert or restart
		logic set_bad;    // skip a non-letter
		logic load_out;   // move counters into the output register
	} lpc_cmd_t;

	typedef struct packed {
		logic letter_ok;
		logic last;
		logic out_free;
	} lpc_stat_t;

endpackage

`default_nettype wire

@@ src/lpc_if.sv @@
// lpc_in_if / lpc_out_if: valid/ready channels of the LZW phrase counter.
// Depends on lpc_pkg for field widths.
`default_nettype none

interface lpc_in_if import lpc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              first;
	logic              last;

	modport source (output valid, output char_code, output first, output last, input ready);
	modport sink   (input valid, input char_code, input first, input last, output ready);
endinterface

interface lpc_out_if import lpc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] phrase_count;
	logic               table_overflow;
	logic               bad_symbol;

	modport source (output valid, output phrase_count, output table_overflow,
		output bad_symbol, input ready);
	modport sink   (input valid, input phrase_count, input table_overflow,
		input bad_symbol, output ready);
endinterface

`default_nettype wire

@@ src/lpc_ctrl.sv @@
// lpc_ctrl: sequencer of the LZW phrase counter; issues datapath commands
// per character. Depends on lpc_pkg.
`default_nettype none

module lpc_ctrl import lpc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_first,
	output logic           in_ready,
	input  wire lpc_stat_t stat,
	output lpc_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADDR,
		S_CHILD,
		S_PARENT,
		S_DECIDE,
		S_FINISH
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_in = in_valid;
				cmd.clear   = in_valid & in_first;
			end
			S_ADDR: begin
				cmd.calc_addr = stat.letter_ok;
				cmd.set_bad   = ~stat.letter_ok;
			end
			S_CHILD:  cmd.rd_child  = 1'b1;
			S_PARENT: cmd.rd_parent = 1'b1;
			S_DECIDE: cmd.decide    = 1'b1;
			S_FINISH: cmd.load_out  = stat.last & stat.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_ADDR;
				S_ADDR:   state_q <= stat.letter_ok ? S_CHILD : S_FINISH;
				S_CHILD:  state_q <= S_PARENT;
				S_PARENT: state_q <= S_DECIDE;
				S_DECIDE: state_q <= S_FINISH;
				S_FINISH: begin
					// hold a finished run until the output register frees up
					if (!stat.last || stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_child_then_parent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_child |=> cmd.rd_parent)
		else $error("parent read did not follow child read");

	a_out_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (stat.last && stat.out_free))
		else $error("result loaded without last or into a full output register");

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.calc_addr, cmd.rd_child, cmd.rd_parent, cmd.decide,
			cmd.set_bad, cmd.load_out, cmd.load_in}))
		else $error("more than one datapath step in a cycle");

endmodule

`default_nettype wire

@@ src/lpc_datapath.sv @@
// lpc_datapath: case folding, child and parent tables, walk state, counters
// and output register of the LZW phrase counter. Depends on lpc_pkg.
`default_nettype none

module lpc_datapath import lpc_pkg::*; #(
	parameter int ALPHABET = LPC_ALPHABET,
	parameter int NODES    = LPC_NODES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lpc_cmd_t           cmd,
	output lpc_stat_t               stat,
	input  wire logic [CHAR_W-1:0]  in_char_code,
	input  wire logic               in_last,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [COUNT_W-1:0]      out_phrase_count,
	output logic                    out_table_overflow,
	output logic                    out_bad_symbol
);

	localparam int NW  = $clog2(NODES);              // stored node id
	localparam int CNW = $clog2(NODES + 1);          // walk node, may reach NODES
	localparam int NFW = $clog2(NODES) + 1;          // allocation counter
	localparam int LW  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int AW  = $clog2(NODES * ALPHABET);
	localparam int DEPTH = NODES * ALPHABET;

	localparam logic [NFW-1:0] FIRST_FREE = NFW'(ALPHABET + 2);
	localparam logic [NFW-1:0] NF_LIMIT   = NFW'(NODES);
	localparam logic [CNW-1:0] NODE_LIMIT = CNW'(NODES);
	localparam logic [CHAR_W-1:0] ALPHA_W = CHAR_W'(ALPHABET);

	// child table: node id of (node, letter); parent table: key of each node.
	// An entry counts only if the child was allocated in this run and its
	// parent key points back, so a new run needs no clearing pass.
	logic [NW-1:0]    child_mem  [DEPTH];
	logic [NW+LW-1:0] parent_mem [NODES];

	logic [LW-1:0]      letter_q;
	logic               letter_ok_q;
	logic               last_q;
	logic [AW-1:0]      addr_q;
	logic [NW-1:0]      child_q;
	logic [NW+LW-1:0]   parent_q;
	logic [CNW-1:0]     cur_q;
	logic [NFW-1:0]     nf_q;
	logic [COUNT_W-1:0] count_q;
	logic               ovf_q;
	logic               bad_q;
	logic               out_valid_q;

	logic [CHAR_W-1:0] folded;
	logic [CHAR_W-1:0] rel;
	logic              is_letter;
	logic [CNW-1:0]    restart;
	logic              node_in;
	logic              room;
	logic              fresh;
	logic              hit;
	logic              do_ins;

	always_comb begin
		folded    = (in_char_code < FOLD_LIMIT) ? in_char_code + CASE_OFFSET : in_char_code;
		rel       = folded - LOWER_A;
		is_letter = (folded >= LOWER_A) && (rel < LETTERS) && (rel < ALPHA_W);
	end

	assign restart = CNW'(letter_q) + CNW'(1);
	assign node_in = cur_q < NODE_LIMIT;
	assign room    = nf_q < NF_LIMIT;
	assign fresh   = (NFW'(child_q) >= FIRST_FREE) && (NFW'(child_q) < nf_q)
		&& (parent_q == {cur_q[NW-1:0], letter_q});

	// written as if-chains so an unknown memory word falls to the miss path
	always_comb begin
		hit = 1'b0;
		if (cur_q == '0) hit = 1'b1;
		else if (fresh) hit = 1'b1;
	end

	always_comb begin
		do_ins = 1'b0;
		if (cmd.decide && node_in) begin
			if (hit) do_ins = 1'b0;
			else if (room) do_ins = 1'b1;
		end
	end

	// input capture and address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_ok_q <= 1'b0;
			last_q      <= 1'b0;
		end else if (cmd.load_in) begin
			letter_ok_q <= is_letter;
			last_q      <= in_last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) letter_q <= rel[LW-1:0];
		if (cmd.calc_addr)
			addr_q <= AW'(cur_q[NW-1:0]) * AW'(ALPHABET) + AW'(letter_q);
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.rd_child) child_q <= child_mem[addr_q];
		if (do_ins) child_mem[addr_q] <= nf_q[NW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_parent) parent_q <= parent_mem[child_q];
		if (do_ins) parent_mem[nf_q[NW-1:0]] <= {cur_q[NW-1:0], letter_q};
	end

	// walk state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			nf_q    <= FIRST_FREE;
			count_q <= COUNT_W'(1);
			ovf_q   <= 1'b0;
			bad_q   <= 1'b0;
		end else if (cmd.clear) begin
			cur_q   <= '0;
			nf_q    <= FIRST_FREE;
			count_q <= COUNT_W'(1);
			ovf_q   <= 1'b0;
			bad_q   <= 1'b0;
		end else if (cmd.set_bad) begin
			bad_q <= 1'b1;
		end else if (cmd.decide) begin
			if (!node_in) begin
				ovf_q <= 1'b1;
				cur_q <= restart;
			end else if (cur_q == '0) begin
				cur_q <= restart;
			end else if (hit) begin
				cur_q <= CNW'(child_q);
			end else if (room) begin
				nf_q  <= nf_q + NFW'(1);
				if (count_q != '1) count_q <= count_q + COUNT_W'(1);
				cur_q <= restart;
			end else begin
				ovf_q <= 1'b1;
				cur_q <= restart;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_phrase_count   <= count_q;
			out_table_overflow <= ovf_q;
			out_bad_symbol     <= bad_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign stat.letter_ok = letter_ok_q;
	assign stat.last      = last_q;
	assign stat.out_free  = ~out_valid_q | out_ready;

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0)
		else $error("phrase count reached zero");

	a_alloc_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.clear |=> nf_q >= $past(nf_q))
		else $error("node allocation went backwards without a new run");

	a_ins_counts: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> nf_q == $past(nf_q) + NFW'(1))
		else $error("insertion did not advance the allocation counter");

endmodule

`default_nettype wire

@@ src/lzw_phrase_counter_top.sv @@
// lzw_phrase_counter_top: LZW phrase counter, controller plus datapath.
// Depends on lpc_pkg, lpc_if, lpc_ctrl, lpc_datapath.
//
// Usage: one character byte per input transaction on in_ch (char_code,
// first, last). Letters of either case walk an LZW trie; non-letters are
// skipped and reported through bad_symbol. A transaction with first set
// starts a new run before its character; one with last set produces one
// result transaction on out_ch (phrase_count, table_overflow, bad_symbol)
// taken after that character.
// Steps: a letter goes from acceptance to the next ready through input
// capture, address multiply, child table read, parent table read, decision
// and finish; a non-letter goes through input capture, a skip step and finish.
// A result is valid in the cycle after the finish step and sits in an
// output register; the next character is accepted while it waits. A
// second result holds the block in its finish step until out_ch drains.
// Reset and first both start a new run directly: table entries are
// qualified against the allocation counter and a per-node parent key, so
// no clearing pass over the tables is needed.
`default_nettype none

module lzw_phrase_counter_top import lpc_pkg::*; #(
	parameter int ALPHABET = LPC_ALPHABET,
	parameter int NODES    = LPC_NODES
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lpc_in_if.sink     in_ch,
	lpc_out_if.source  out_ch
);

	lpc_cmd_t  cmd;
	lpc_stat_t stat;

	lpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_first (in_ch.first),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lpc_datapath #(
		.ALPHABET (ALPHABET),
		.NODES    (NODES)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.in_char_code       (in_ch.char_code),
		.in_last            (in_ch.last),
		.out_valid          (out_ch.valid),
		.out_ready          (out_ch.ready),
		.out_phrase_count   (out_ch.phrase_count),
		.out_table_overflow (out_ch.table_overflow),
		.out_bad_symbol     (out_ch.bad_symbol)
	);

endmodule

`default_nettype wire
